// ===== src/bra_pkg.sv =====
`default_nettype none

package bra_pkg;

   localparam int MAX_BYTES = 512;
   localparam int BYTE_W    = 8;
   localparam int ADDR_W    = $clog2(MAX_BYTES);
   localparam int CFG_W     = 10;
   localparam int OP_W      = 3;
   localparam int INDEX_W   = 12;
   localparam int LEN_W     = 13;

   localparam logic [OP_W-1:0] OP_TEST  = 3'd0;
   localparam logic [OP_W-1:0] OP_SET   = 3'd1;
   localparam logic [OP_W-1:0] OP_CLEAR = 3'd2;
   localparam logic [OP_W-1:0] OP_SCAN  = 3'd3;
   localparam logic [OP_W-1:0] OP_WIPE  = 3'd4;

endpackage

`default_nettype wire

// ===== src/bitmap_run_allocator.sv =====
`default_nettype none

// First-fit allocation bitmap of 512 bytes held in a memory with a registered read.
// One transaction is taken at a time, and req_stall stays high until it has been worked
// off. Test, set and clear read the map byte, then test or update the bit, then post the
// result. A scan reads one map byte per cycle, checks its eight bits against the running
// count of free bits, and stops at the first run that is long enough or at the last byte in
// use. Clear-all writes every map byte once. A request that is rejected with an error, a
// scan of an empty map and an unknown operation go straight to posting their result.
// After reset the same clearing pass runs before the first transaction is taken; the size
// register may be written during that time. Results sit in an output register, so a new
// transaction may start while the previous result still waits to be taken.

module bitmap_run_allocator (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           csr_write_enable,
   input  wire [bra_pkg::CFG_W-1:0]      csr_write_data,
   input  wire                           req_valid,
   output logic                          req_stall,
   input  wire [bra_pkg::OP_W-1:0]       req_operation,
   input  wire [bra_pkg::INDEX_W-1:0]    req_bit_index,
   input  wire [bra_pkg::LEN_W-1:0]      req_run_length,
   output logic                          rsp_valid,
   input  wire                           rsp_stall,
   output logic                          rsp_bit_value,
   output logic                          rsp_found,
   output logic [bra_pkg::INDEX_W-1:0]   rsp_start_index,
   output logic                          rsp_request_error
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_BITR = 3'd1;
   localparam logic [2:0] S_BITW = 3'd2;
   localparam logic [2:0] S_SCAN = 3'd3;
   localparam logic [2:0] S_SFIN = 3'd4;
   localparam logic [2:0] S_CLR  = 3'd5;
   localparam logic [2:0] S_POST = 3'd6;

   localparam int AW = bra_pkg::ADDR_W;
   localparam int BW = bra_pkg::BYTE_W;
   localparam int IW = bra_pkg::INDEX_W;
   localparam int LW = bra_pkg::LEN_W;
   localparam int CW = bra_pkg::CFG_W;

   logic [BW-1:0] alloc_mem [bra_pkg::MAX_BYTES];
   logic [BW-1:0] rd_data_ff;
   logic [AW-1:0] mem_ra;
   logic [AW-1:0] mem_wa;
   logic [BW-1:0] mem_wd;
   logic          mem_we;

   logic [2:0]          state_ff, state_in;
   logic                init_ff, init_in;
   logic [CW-1:0]       bytes_in_use_ff, bytes_in_use_in;
   logic [bra_pkg::OP_W-1:0] op_ff, op_in;
   logic [AW-1:0]       byte_ff, byte_in;
   logic [2:0]          bitsel_ff, bitsel_in;
   logic [LW-1:0]       len_ff, len_in;
   logic [AW-1:0]       addr_ff, addr_in;
   logic [AW-1:0]       pidx_ff, pidx_in;
   logic                scan_vld_ff, scan_vld_in;
   logic [LW-1:0]       run_ff, run_in;
   logic [IW-1:0]       end_ff, end_in;
   logic                res_value_ff, res_value_in;
   logic                res_found_ff, res_found_in;
   logic [IW-1:0]       res_start_ff, res_start_in;
   logic                res_err_ff, res_err_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_value_ff, rsp_value_in;
   logic                rsp_found_ff, rsp_found_in;
   logic [IW-1:0]       rsp_start_ff, rsp_start_in;
   logic                rsp_err_ff, rsp_err_in;

   logic [CW-1:0]       nbytes;
   logic [LW-1:0]       nbits;
   logic [AW-1:0]       last_byte;
   logic [LW-1:0]       run_v;
   logic                hit;
   logic [IW-1:0]       hit_pos;
   logic [BW-1:0]       bit_mask;
   logic                sel_bit;
   logic                accept;

   assign nbytes    = (bytes_in_use_ff > CW'(bra_pkg::MAX_BYTES)) ?
                      CW'(bra_pkg::MAX_BYTES) : bytes_in_use_ff;
   assign nbits     = {nbytes, 3'b000};
   assign last_byte = AW'(nbytes - CW'(1));
   assign bit_mask  = BW'(1) << bitsel_ff;
   assign sel_bit   = rd_data_ff[bitsel_ff];
   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;

   // Count free bits across the current map byte, lowest bit first.
   always_comb begin
      run_v   = run_ff;
      hit     = 1'b0;
      hit_pos = '0;
      for (int j = 0; j < BW; j++) begin
         if (!hit) begin
            if (rd_data_ff[j]) begin
               run_v = '0;
            end else begin
               run_v = run_v + LW'(1);
               if (run_v == len_ff) begin
                  hit     = 1'b1;
                  hit_pos = {pidx_ff, 3'(j)};
               end
            end
         end
      end
   end

   always_comb begin
      mem_ra = byte_ff;
      mem_wa = byte_ff;
      mem_wd = rd_data_ff;
      mem_we = 1'b0;
      case (state_ff)
         S_SCAN: begin
            mem_ra = addr_ff;
         end
         S_BITW: begin
            if (op_ff == bra_pkg::OP_SET) begin
               mem_we = 1'b1;
               mem_wd = rd_data_ff | bit_mask;
            end else if (op_ff == bra_pkg::OP_CLEAR) begin
               mem_we = 1'b1;
               mem_wd = rd_data_ff & ~bit_mask;
            end
         end
         S_CLR: begin
            mem_we = 1'b1;
            mem_wa = addr_ff;
            mem_wd = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         alloc_mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= alloc_mem[mem_ra];
   end

   always_comb begin
      state_in        = state_ff;
      init_in         = init_ff;
      bytes_in_use_in = csr_write_enable ? csr_write_data : bytes_in_use_ff;
      op_in           = op_ff;
      byte_in         = byte_ff;
      bitsel_in       = bitsel_ff;
      len_in          = len_ff;
      addr_in         = addr_ff;
      pidx_in         = addr_ff;
      scan_vld_in     = 1'b0;
      run_in          = run_ff;
      end_in          = end_ff;
      res_value_in    = res_value_ff;
      res_found_in    = res_found_ff;
      res_start_in    = res_start_ff;
      res_err_in      = res_err_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_value_in    = rsp_value_ff;
      rsp_found_in    = rsp_found_ff;
      rsp_start_in    = rsp_start_ff;
      rsp_err_in      = rsp_err_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in        = req_operation;
               byte_in      = req_bit_index[3 +: AW];
               bitsel_in    = req_bit_index[2:0];
               len_in       = req_run_length;
               addr_in      = '0;
               run_in       = '0;
               res_value_in = 1'b0;
               res_found_in = 1'b0;
               res_start_in = '0;
               res_err_in   = 1'b0;
               state_in     = S_POST;
               case (req_operation)
                  bra_pkg::OP_TEST, bra_pkg::OP_SET, bra_pkg::OP_CLEAR: begin
                     if ({1'b0, req_bit_index} >= nbits) begin
                        res_err_in = 1'b1;
                     end else begin
                        state_in = S_BITR;
                     end
                  end
                  bra_pkg::OP_SCAN: begin
                     if (req_run_length == '0) begin
                        res_err_in = 1'b1;
                     end else if (nbytes != '0) begin
                        state_in = S_SCAN;
                     end
                  end
                  bra_pkg::OP_WIPE: begin
                     state_in = S_CLR;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_BITR: begin
            state_in = S_BITW;
         end
         S_BITW: begin
            if (op_ff == bra_pkg::OP_TEST) begin
               res_value_in = sel_bit;
            end
            state_in = S_POST;
         end
         S_SCAN: begin
            if (addr_ff != last_byte) begin
               addr_in = addr_ff + AW'(1);
            end
            scan_vld_in = 1'b1;
            if (scan_vld_ff) begin
               run_in = run_v;
               if (hit || pidx_ff == last_byte) begin
                  res_found_in = hit;
                  end_in       = hit_pos;
                  scan_vld_in  = 1'b0;
                  state_in     = S_SFIN;
               end
            end
         end
         S_SFIN: begin
            if (res_found_ff) begin
               res_start_in = IW'({1'b0, end_ff} + LW'(1) - len_ff);
            end
            state_in = S_POST;
         end
         S_CLR: begin
            addr_in = addr_ff + AW'(1);
            if (addr_ff == AW'(bra_pkg::MAX_BYTES - 1)) begin
               init_in  = 1'b0;
               state_in = init_ff ? S_IDLE : S_POST;
            end
         end
         S_POST: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = res_value_ff;
               rsp_found_in = res_found_ff;
               rsp_start_in = res_start_ff;
               rsp_err_in   = res_err_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_CLR;
         init_ff         <= 1'b1;
         bytes_in_use_ff <= CW'(bra_pkg::MAX_BYTES);
         addr_ff         <= '0;
         scan_vld_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         init_ff         <= init_in;
         bytes_in_use_ff <= bytes_in_use_in;
         addr_ff         <= addr_in;
         scan_vld_ff     <= scan_vld_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      op_ff        <= op_in;
      byte_ff      <= byte_in;
      bitsel_ff    <= bitsel_in;
      len_ff       <= len_in;
      pidx_ff      <= pidx_in;
      run_ff       <= run_in;
      end_ff       <= end_in;
      res_value_ff <= res_value_in;
      res_found_ff <= res_found_in;
      res_start_ff <= res_start_in;
      res_err_ff   <= res_err_in;
      rsp_value_ff <= rsp_value_in;
      rsp_found_ff <= rsp_found_in;
      rsp_start_ff <= rsp_start_in;
      rsp_err_ff   <= rsp_err_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_bit_value     = rsp_value_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_start_index   = rsp_start_ff;
   assign rsp_request_error = rsp_err_ff;

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

   localparam int OW          = bra_pkg::OP_W;
   localparam int IW          = bra_pkg::INDEX_W;
   localparam int LW          = bra_pkg::LEN_W;
   localparam int CW          = bra_pkg::CFG_W;
   localparam int TOP_BIT     = bra_pkg::MAX_BYTES * bra_pkg::BYTE_W - 1;
   localparam int OP_LAST     = (1 << OW) - 1;
   localparam int QUIET_LIMIT = 5000;
   localparam int TAIL_CYCLES = 600;
   localparam int HOLD_CYCLES = 300;

   localparam logic [IW-1:0] TOP_INDEX = IW'(TOP_BIT);

   typedef struct packed {
      logic           bit_value;
      logic           found;
      logic [IW-1:0]  start_index;
      logic           request_error;
   } alloc_reply_type;

   logic                clock;
   logic                reset;
   logic                csr_write_enable;
   logic [CW-1:0]       csr_write_data;
   logic                req_valid;
   logic                req_stall;
   logic [OW-1:0]       req_operation;
   logic [IW-1:0]       req_bit_index;
   logic [LW-1:0]       req_run_length;
   logic                rsp_valid;
   logic                rsp_stall;
   logic                rsp_bit_value;
   logic                rsp_found;
   logic [IW-1:0]       rsp_start_index;
   logic                rsp_request_error;

   logic [TOP_BIT:0]            alloc_map;
   int unsigned                 map_bytes;
   alloc_reply_type             expected_replies[$];
   int                          mismatch_count = 0;
   bit                          idle_enable;
   int                          hold_request;
   bit                          hold_taken = 1'b0;
   int                          stall_left = 0;

   bitmap_run_allocator DUT (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_bit_index     (req_bit_index),
      .req_run_length    (req_run_length),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_bit_value     (rsp_bit_value),
      .rsp_found         (rsp_found),
      .rsp_start_index   (rsp_start_index),
      .rsp_request_error (rsp_request_error)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   function automatic int unsigned map_bit_count();
      int unsigned used;
      used = (map_bytes > bra_pkg::MAX_BYTES) ? bra_pkg::MAX_BYTES : map_bytes;
      return used * bra_pkg::BYTE_W;
   endfunction

   function automatic alloc_reply_type apply_request(input logic [OW-1:0] op,
                                                     input logic [IW-1:0] idx,
                                                     input logic [LW-1:0] len);
      alloc_reply_type reply;
      int unsigned     nbits;
      int unsigned     run;
      int unsigned     pos;
      reply = '0;
      nbits = map_bit_count();
      case (op)
         bra_pkg::OP_TEST, bra_pkg::OP_SET, bra_pkg::OP_CLEAR: begin
            if (idx >= nbits) begin
               reply.request_error = 1'b1;
            end else if (op == bra_pkg::OP_TEST) begin
               reply.bit_value = alloc_map[idx];
            end else begin
               alloc_map[idx] = (op == bra_pkg::OP_SET);
            end
         end
         bra_pkg::OP_SCAN: begin
            if (len == 0) begin
               reply.request_error = 1'b1;
            end else begin
               run = 0;
               for (pos = 0; pos < nbits && !reply.found; pos++) begin
                  if (alloc_map[pos]) begin
                     run = 0;
                  end else begin
                     run++;
                     if (run == len) begin
                        reply.found       = 1'b1;
                        reply.start_index = IW'(pos + 1 - len);
                     end
                  end
               end
            end
         end
         bra_pkg::OP_WIPE: begin
            alloc_map = '0;
         end
         default: begin
         end
      endcase
      return reply;
   endfunction

   function automatic string reply_text(input alloc_reply_type r);
      return $sformatf("value=%b found=%b start=%0d error=%b",
                       r.bit_value, r.found, r.start_index, r.request_error);
   endfunction

   task automatic send_request(input logic [OW-1:0] op, input logic [IW-1:0] idx,
                               input logic [LW-1:0] len);
      int gap;
      int roll;
      gap = 0;
      if (idle_enable) begin
         roll = $urandom_range(0, 99);
         if (roll >= 95) begin
            gap = $urandom_range(10, 40);
         end else if (roll >= 70) begin
            gap = $urandom_range(1, 3);
         end
      end
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_operation  <= op;
      req_bit_index  <= idx;
      req_run_length <= len;
      do @(posedge clock); while (!(req_valid && !req_stall));
      expected_replies.push_back(apply_request(op, idx, len));
   endtask

   task automatic wait_for_replies();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_replies.size() != 0) @(negedge clock);
   endtask

   task automatic write_map_bytes(input logic [CW-1:0] value);
      wait_for_replies();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      map_bytes = 32'(value);
   endtask

   task automatic send_random_request();
      int unsigned    nbits;
      int unsigned    roll;
      logic [OW-1:0]  op;
      logic [IW-1:0]  idx;
      logic [LW-1:0]  len;
      nbits = map_bit_count();
      roll  = $urandom_range(0, 99);
      op    = OW'($urandom);
      idx   = IW'($urandom_range(0, TOP_BIT));
      len   = LW'($urandom);
      if (nbits != 0 && roll < 55) begin
         idx = IW'($urandom_range(0, nbits - 1));
      end
      if (roll < 30) begin
         op = bra_pkg::OP_SET;
      end else if (roll < 42) begin
         op = bra_pkg::OP_CLEAR;
      end else if (roll < 55) begin
         op = bra_pkg::OP_TEST;
      end else if (roll < 80) begin
         op  = bra_pkg::OP_SCAN;
         len = LW'($urandom_range(1, 12));
      end else if (roll < 85) begin
         op  = bra_pkg::OP_SCAN;
         len = LW'($urandom_range(1, nbits + 8));
      end else if (roll < 88) begin
         op = bra_pkg::OP_WIPE;
      end
      send_request(op, idx, len);
   endtask

   task automatic report_mismatch(input string what, input alloc_reply_type want,
                                  input alloc_reply_type got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%0t %s: expected %s, got %s", $realtime, what, reply_text(want),
                  reply_text(got));
      end
   endtask

   always @(posedge clock) begin : result_check
      alloc_reply_type want;
      alloc_reply_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_bit_value, rsp_found, rsp_start_index, rsp_request_error};
         if (expected_replies.size() == 0) begin
            report_mismatch("unexpected transaction", '0, got);
         end else begin
            want = expected_replies.pop_front();
            if (got !== want) begin
               report_mismatch("wrong transaction", want, got);
            end
         end
      end
   end

   always @(negedge clock) begin : result_stall
      int roll;
      if (hold_request != 0 && !hold_taken) begin
         stall_left = hold_request;
         hold_taken = 1'b1;
      end
      if (stall_left == 0 && idle_enable) begin
         roll = $urandom_range(0, 99);
         if (roll >= 97) begin
            stall_left = $urandom_range(20, 80);
         end else if (roll >= 75) begin
            stall_left = $urandom_range(1, 3);
         end
      end
      if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("end of test: mismatches");
      $finish;
   end

   task automatic test_bit_operations();
      int code;
      send_request(bra_pkg::OP_TEST, '0, '0);
      send_request(bra_pkg::OP_SET, '0, '0);
      send_request(bra_pkg::OP_TEST, '0, '0);
      send_request(bra_pkg::OP_SET, TOP_INDEX, '0);
      send_request(bra_pkg::OP_TEST, TOP_INDEX, '0);
      send_request(bra_pkg::OP_CLEAR, TOP_INDEX, '0);
      send_request(bra_pkg::OP_TEST, TOP_INDEX, '0);
      for (code = bra_pkg::OP_WIPE + 1; code <= OP_LAST; code++) begin
         send_request(OW'(code), TOP_INDEX, '1);
      end
   endtask

   task automatic test_run_scan();
      send_request(bra_pkg::OP_SET, TOP_INDEX, '0);
      send_request(bra_pkg::OP_SCAN, '0, LW'(1));
      send_request(bra_pkg::OP_SCAN, '0, LW'(TOP_BIT - 1));
      send_request(bra_pkg::OP_SCAN, '0, LW'(TOP_BIT));
      send_request(bra_pkg::OP_SCAN, TOP_INDEX, '0);
      send_request(bra_pkg::OP_SCAN, '0, '1);
      send_request(bra_pkg::OP_WIPE, '0, '0);
      send_request(bra_pkg::OP_SCAN, '0, LW'(TOP_BIT + 1));
   endtask

   task automatic test_map_size();
      write_map_bytes(CW'(1));
      send_request(bra_pkg::OP_SET, IW'(7), '0);
      send_request(bra_pkg::OP_TEST, IW'(8), '0);
      send_request(bra_pkg::OP_SCAN, '0, LW'(7));
      send_request(bra_pkg::OP_SCAN, '0, LW'(8));
      write_map_bytes('0);
      send_request(bra_pkg::OP_TEST, '0, '0);
      send_request(bra_pkg::OP_SCAN, '0, LW'(1));
      write_map_bytes('1);
      send_request(bra_pkg::OP_SCAN, '0, LW'(TOP_BIT + 1));
      send_request(bra_pkg::OP_WIPE, '0, '0);
   endtask

   task automatic test_backpressure();
      write_map_bytes(CW'(4));
      hold_request = HOLD_CYCLES;
      repeat (12) send_random_request();
      wait_for_replies();
   endtask

   task automatic test_random_traffic();
      int             phase;
      int             roll;
      logic [CW-1:0]  size;
      for (phase = 0; phase < 10; phase++) begin
         roll = $urandom_range(0, 99);
         if (phase == 0) begin
            size = CW'(bra_pkg::MAX_BYTES);
         end else if (phase == 1) begin
            size = '1;
         end else if (phase == 2) begin
            size = '0;
         end else if (roll < 60) begin
            size = CW'($urandom_range(1, 8));
         end else if (roll < 85) begin
            size = CW'($urandom_range(9, 64));
         end else begin
            size = CW'($urandom_range(65, 1023));
         end
         write_map_bytes(size);
         idle_enable = (phase % 3 != 2);
         repeat (38) send_random_request();
      end
      idle_enable = 1'b1;
   endtask

   initial begin
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      req_valid        = 1'b0;
      req_operation    = bra_pkg::OP_TEST;
      req_bit_index    = '0;
      req_run_length   = '0;
      alloc_map        = '0;
      map_bytes        = bra_pkg::MAX_BYTES;
      idle_enable      = 1'b1;
      hold_request     = 0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      test_bit_operations();
      test_run_scan();
      test_map_size();
      test_backpressure();
      test_random_traffic();

      wait_for_replies();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_replies.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
